>>> src/spq_pkg.sv
// Shared types and codes for the stable priority queue.
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int PRIO_W    = 16;
  localparam int PAYLOAD_W = 32;
  localparam int STATUS_W  = 2;

  // Operation codes carried in the op field
  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_ENQUEUED = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DEQUEUED = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 2'd3;

  typedef logic signed [PRIO_W-1:0] prio_t;
  typedef logic [PAYLOAD_W-1:0]     payload_t;
  typedef logic [STATUS_W-1:0]      status_code_t;

  // Controller to datapath
  typedef struct packed {
    logic         load;  // capture the input transaction
    logic         exec;  // apply the held item to the cells, load the output
    status_code_t code;  // outcome of the held item
  } spq_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic item_deq;  // held item is a dequeue
    logic empty;
    logic full;
  } spq_stat_t;

endpackage : spq_pkg

`default_nettype wire

>>> src/spq_ctrl.sv
// Handshake controller for the stable priority queue.
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl
  import spq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire spq_stat_t stat,
  output spq_cmd_t       cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_BUSY = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic exec;
  logic load;

  // Execute once the output register is free or being emptied this cycle
  assign exec     = (state == ST_BUSY) && (!out_valid || out_ready);
  assign in_ready = (state == ST_IDLE) || exec;
  assign load     = in_valid && in_ready;

  always_comb begin
    cmd.load = load;
    cmd.exec = exec;
    if (stat.item_deq) begin
      cmd.code = stat.empty ? STAT_EMPTY : STAT_DEQUEUED;
    end else begin
      cmd.code = stat.full ? STAT_FULL : STAT_ENQUEUED;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (load) state_next = ST_BUSY;
      end
      ST_BUSY: begin
        if (exec && !load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (exec) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule : spq_ctrl

`default_nettype wire

>>> src/spq_datapath.sv
// Sorted shift-register cells, item register and result register.
`timescale 1ns / 1ps
`default_nettype none

module spq_datapath
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire spq_cmd_t     cmd,
  output spq_stat_t         stat,
  input  wire logic         op,
  input  wire prio_t        priority_req,
  input  wire payload_t     payload,
  output status_code_t      status,
  output payload_t          out_payload,
  output prio_t             out_priority
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic            item_op;
  prio_t           item_prio;
  payload_t        item_payload;
  logic [CNT_W-1:0] count;

  prio_t    cell_prio    [QUEUE_DEPTH];
  payload_t cell_payload [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] ge;

  logic do_enq;
  logic do_deq;

  assign do_enq = cmd.exec && (cmd.code == STAT_ENQUEUED);
  assign do_deq = cmd.exec && (cmd.code == STAT_DEQUEUED);

  assign stat.item_deq = (item_op == OP_DEQ);
  assign stat.empty    = (count == '0);
  assign stat.full     = (count == CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op      <= op;
      item_prio    <= priority_req;
      item_payload <= payload;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (do_enq) begin
      count <= count + CNT_W'(1);
    end else if (do_deq) begin
      count <= count - CNT_W'(1);
    end
  end

  // Each cell compares locally; the occupied cells with ge set form a prefix
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic prev_ge;

    assign ge[i] = (count > CNT_W'(i)) && (cell_prio[i] >= item_prio);

    if (i == 0) begin : g_head
      assign prev_ge = 1'b1;
    end else begin : g_body
      assign prev_ge = ge[i-1];
    end

    always_ff @(posedge clk) begin
      if (do_enq && !ge[i]) begin
        if (prev_ge) begin
          cell_prio[i]    <= item_prio;
          cell_payload[i] <= item_payload;
        end else begin
          // Shift towards the tail to make room behind equal priorities
          cell_prio[i]    <= cell_prio[(i == 0) ? 0 : i-1];
          cell_payload[i] <= cell_payload[(i == 0) ? 0 : i-1];
        end
      end else if (do_deq && (i < QUEUE_DEPTH - 1)) begin
        cell_prio[i]    <= cell_prio[(i < QUEUE_DEPTH - 1) ? i+1 : i];
        cell_payload[i] <= cell_payload[(i < QUEUE_DEPTH - 1) ? i+1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status <= cmd.code;
      if (cmd.code == STAT_DEQUEUED) begin
        out_payload  <= cell_payload[0];
        out_priority <= cell_prio[0];
      end else begin
        out_payload  <= '0;
        out_priority <= '0;
      end
    end
  end

endmodule : spq_datapath

`default_nettype wire

>>> src/stable_priority_queue_core.sv
// Top level of the stable priority queue.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------
//  input    | in_valid / in_ready  | op, priority_req, payload
//  output   | out_valid / out_ready| status, out_payload, out_priority
//
// A transaction is first captured in the item register, then applied to the
// row of cells as its result is loaded into the output register. One
// transaction per cycle is sustained while results are taken. Reset clears
// the entry count and the handshake state; cell contents are not cleared. A
// stalled output holds its result, the pending item waits in the item
// register and in_ready drops until the output frees.
`timescale 1ns / 1ps
`default_nettype none

module stable_priority_queue_core
  import spq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     op,
  input  wire prio_t    priority_req,
  input  wire payload_t payload,
  output logic          out_valid,
  input  wire logic     out_ready,
  output status_code_t  status,
  output payload_t      out_payload,
  output prio_t         out_priority
);

  spq_cmd_t  cmd;
  spq_stat_t stat;

  spq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  spq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (op),
    .priority_req (priority_req),
    .payload      (payload),
    .status       (status),
    .out_payload  (out_payload),
    .out_priority (out_priority)
  );

endmodule : stable_priority_queue_core

`default_nettype wire
